// ===== hdl/wic_pkg.sv =====
// Shared constants, command codes and control structs for the wrapped image convolution unit.
`timescale 1ns / 1ps
`default_nettype none

package wic_pkg;

	// Default sizes for the top-level parameters.
	localparam int MAX_SIDE_DEF   = 256;
	localparam int MAX_KERNEL_DEF = 5;

	// Field widths of the channels.
	localparam int CMD_W       = 2;
	localparam int POS_IN_W    = 8;
	localparam int COEF_IDX_W  = 5;
	localparam int COEF_W      = 8;
	localparam int CHAN_W      = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 9;
	localparam int SIDE_CFG_W  = 9;
	localparam int KSIZE_CFG_W = 3;

	// Bits of the counter that walks the row and column bits in the remainder unit.
	localparam int BIT_CNT_W = $clog2(POS_IN_W);

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_COEF  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CONV  = 2'd2;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KSIZE  = 2'd2;

	// Register reset values.
	localparam logic [SIDE_CFG_W-1:0]  RST_WIDTH  = 9'd256;
	localparam logic [SIDE_CFG_W-1:0]  RST_HEIGHT = 9'd256;
	localparam logic [KSIZE_CFG_W-1:0] RST_KSIZE  = 3'd3;

	typedef struct packed {
		logic coef_we;
		logic pixel_we;
		logic mod_start;
		logic mod_step;
		logic back_step;
		logic issue;
		logic row_end;
		logic last;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic acc_done;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/wic_if.sv =====
// Channel interfaces of the wrapped image convolution unit: items, results and register writes.
`timescale 1ns / 1ps
`default_nettype none

interface wic_in_if import wic_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [CMD_W-1:0]             command;
	logic [POS_IN_W-1:0]          row;
	logic [POS_IN_W-1:0]          col;
	logic [COEF_IDX_W-1:0]        coef_index;
	logic signed [COEF_W-1:0]     coef_value;
	logic [CHAN_W-1:0]            red;
	logic [CHAN_W-1:0]            green;
	logic [CHAN_W-1:0]            blue;

	modport source (
		output valid, command, row, col, coef_index, coef_value, red, green, blue,
		input  ready
	);
	modport sink (
		input  valid, command, row, col, coef_index, coef_value, red, green, blue,
		output ready
	);
endinterface

interface wic_out_if import wic_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] out_red;
	logic [CHAN_W-1:0] out_green;
	logic [CHAN_W-1:0] out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

interface wic_cfg_if import wic_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/wic_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module wic_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/wic_cfg.sv =====
// Configuration registers and the clamped active image and kernel sizes derived from them.
`timescale 1ns / 1ps
`default_nettype none

module wic_cfg import wic_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF,
	parameter int MAX_KERNEL = MAX_KERNEL_DEF,
	localparam int SZ_W = $clog2(MAX_SIDE + 1),
	localparam int KS_W = $clog2(MAX_KERNEL + 1)
) (
	input  logic            clk,
	input  logic            arst_n,
	wic_cfg_if.sink         cfg,
	output logic [SZ_W-1:0] act_width,
	output logic [SZ_W-1:0] act_height,
	output logic [KS_W-1:0] act_ksize,
	output logic [KS_W-1:0] act_half
);

	logic [SIDE_CFG_W-1:0]  width_q;
	logic [SIDE_CFG_W-1:0]  height_q;
	logic [KSIZE_CFG_W-1:0] ksize_q;
	logic [KS_W-1:0]        ksat;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			ksize_q  <= RST_KSIZE;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_WIDTH:  width_q  <= SIDE_CFG_W'(cfg.data);
				REG_HEIGHT: height_q <= SIDE_CFG_W'(cfg.data);
				REG_KSIZE:  ksize_q  <= KSIZE_CFG_W'(cfg.data);
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			act_width = SZ_W'(1);
		end else if (32'(width_q) > MAX_SIDE) begin
			act_width = SZ_W'(MAX_SIDE);
		end else begin
			act_width = SZ_W'(width_q);
		end

		if (height_q == '0) begin
			act_height = SZ_W'(1);
		end else if (32'(height_q) > MAX_SIDE) begin
			act_height = SZ_W'(MAX_SIDE);
		end else begin
			act_height = SZ_W'(height_q);
		end

		if (32'(ksize_q) > MAX_KERNEL) begin
			ksat = KS_W'(MAX_KERNEL);
		end else if (ksize_q == '0) begin
			ksat = KS_W'(1);
		end else begin
			ksat = KS_W'(ksize_q);
		end
		// Even sizes drop to the odd size below them so the window stays centered.
		act_ksize = ksat[0] ? ksat : ksat - 1'b1;
		act_half  = act_ksize >> 1;
	end

endmodule

`default_nettype wire

// ===== hdl/wic_ctrl.sv =====
// Controller state machine that sequences writes, the wrap setup and the kernel tap walk.
`timescale 1ns / 1ps
`default_nettype none

module wic_ctrl import wic_pkg::*; #(
	parameter int MAX_KERNEL = MAX_KERNEL_DEF,
	localparam int KS_W = $clog2(MAX_KERNEL + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic [CMD_W-1:0] item_command,
	output logic             item_ready,
	input  logic [KS_W-1:0]  act_ksize,
	input  logic [KS_W-1:0]  act_half,
	output ctrl_cmd_t        cmd,
	input  dp_status_t       status
);

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_MOD    = 6'b000010,
		ST_BACK   = 6'b000100,
		ST_RUN    = 6'b001000,
		ST_DRAIN  = 6'b010000,
		ST_RESULT = 6'b100000
	} state_t;

	state_t               state_q, state_d;
	logic [BIT_CNT_W-1:0] bit_q, bit_d;
	logic [KS_W-1:0]      step_q, step_d;
	logic [KS_W-1:0]      a_q, a_d;
	logic [KS_W-1:0]      b_q, b_d;
	logic [KS_W-1:0]      k_max;

	assign k_max = act_ksize - 1'b1;

	always_comb begin
		state_d    = state_q;
		bit_d      = bit_q;
		step_d     = step_q;
		a_d        = a_q;
		b_d        = b_q;
		cmd        = '0;
		item_ready = (state_q == ST_IDLE);

		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					case (item_command)
						CMD_COEF:  cmd.coef_we = 1'b1;
						CMD_PIXEL: cmd.pixel_we = 1'b1;
						CMD_CONV: begin
							cmd.mod_start = 1'b1;
							bit_d         = '0;
							state_d       = ST_MOD;
						end
						default: ;
					endcase
				end
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				bit_d        = bit_q + 1'b1;
				if (bit_q == BIT_CNT_W'(POS_IN_W - 1)) begin
					step_d  = '0;
					a_d     = '0;
					b_d     = '0;
					state_d = (act_half == '0) ? ST_RUN : ST_BACK;
				end
			end
			ST_BACK: begin
				// Step the window origin back by half a kernel, each step wrapping at the edge.
				cmd.back_step = 1'b1;
				step_d        = step_q + 1'b1;
				if (step_q == act_half - 1'b1) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.issue   = 1'b1;
				cmd.row_end = (b_q == k_max);
				cmd.last    = (b_q == k_max) && (a_q == k_max);
				if (b_q == k_max) begin
					b_d = '0;
					a_d = (a_q == k_max) ? '0 : a_q + 1'b1;
				end else begin
					b_d = b_q + 1'b1;
				end
				if (cmd.last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (status.acc_done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
			step_q  <= '0;
			a_q     <= '0;
			b_q     <= '0;
		end else begin
			state_q <= state_d;
			bit_q   <= bit_d;
			step_q  <= step_d;
			a_q     <= a_d;
			b_q     <= b_d;
		end
	end

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		status.acc_done |-> state_q == ST_DRAIN)
		else $error("accumulation finished outside the drain phase");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.out_free)
		else $error("result register loaded while still holding an untaken result");

	a_walk_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && $past(state_q) == ST_RUN) |-> (a_q == '0 && b_q == '0))
		else $error("tap walk ended with kernel counters not wrapped");

	a_conv_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && item_valid && item_command == CMD_CONV)
		|=> (state_q == ST_MOD && bit_q == '0))
		else $error("compute transfer did not start the remainder phase");

endmodule

`default_nettype wire

// ===== hdl/wic_dp.sv =====
// Datapath: frame and kernel stores, wrapped position tracking, MAC pipeline and result register.
`timescale 1ns / 1ps
`default_nettype none

module wic_dp import wic_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF,
	parameter int MAX_KERNEL = MAX_KERNEL_DEF,
	localparam int SZ_W = $clog2(MAX_SIDE + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_cmd_t                cmd,
	output dp_status_t               status,
	input  logic [SZ_W-1:0]          act_width,
	input  logic [SZ_W-1:0]          act_height,
	input  logic [POS_IN_W-1:0]      row,
	input  logic [POS_IN_W-1:0]      col,
	input  logic [COEF_IDX_W-1:0]    coef_index,
	input  logic signed [COEF_W-1:0] coef_value,
	input  logic [CHAN_W-1:0]        red,
	input  logic [CHAN_W-1:0]        green,
	input  logic [CHAN_W-1:0]        blue,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [CHAN_W-1:0]        out_red,
	output logic [CHAN_W-1:0]        out_green,
	output logic [CHAN_W-1:0]        out_blue
);

	localparam int POS_W   = $clog2(MAX_SIDE);
	localparam int TRIAL_W = POS_W + 1;
	localparam int FA_W    = 2 * POS_W;
	localparam int FDEPTH  = MAX_SIDE * MAX_SIDE;
	localparam int KDEPTH  = MAX_KERNEL * MAX_KERNEL;
	localparam int KA_W    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
	localparam int PIX_W   = 3 * CHAN_W;
	localparam int PROD_W  = COEF_W + CHAN_W + 1;
	localparam int ACC_W   = PROD_W + $clog2(KDEPTH);

	// Window position: nr_q/nc_q also serve as the remainders during the modulo phase.
	logic [POS_W-1:0]    nr_q, nc_q, nc0_q;
	logic [POS_IN_W-1:0] rowsh_q, colsh_q;
	logic [KA_W-1:0]     kidx_q;

	logic [TRIAL_W-1:0] row_trial, col_trial;
	logic [POS_W-1:0]   nr_mod, nc_mod, nr_dec, nc0_dec, nr_inc, nc_inc;

	logic [PIX_W-1:0]  pix_rd;
	logic [COEF_W-1:0] coef_rd;
	logic              kern_we;

	logic                     v_s1, last_s1, v_s2, last_s2;
	logic signed [PROD_W-1:0] prod_r_s2, prod_g_s2, prod_b_s2;
	logic signed [ACC_W-1:0]  acc_r_q, acc_g_q, acc_b_q;

	logic              out_valid_q;
	logic [CHAN_W-1:0] out_red_q, out_green_q, out_blue_q;

	function automatic logic [CHAN_W-1:0] abs_low(input logic signed [ACC_W-1:0] s);
		logic [CHAN_W-1:0] lo;
		lo = s[CHAN_W-1:0];
		return s[ACC_W-1] ? (~lo + 1'b1) : lo;
	endfunction

	// One restoring remainder step per cycle, most significant bit first.
	always_comb begin
		row_trial = {nr_q, rowsh_q[POS_IN_W-1]};
		col_trial = {nc_q, colsh_q[POS_IN_W-1]};
		nr_mod = (row_trial >= TRIAL_W'(act_height))
			? POS_W'(row_trial - TRIAL_W'(act_height)) : POS_W'(row_trial);
		nc_mod = (col_trial >= TRIAL_W'(act_width))
			? POS_W'(col_trial - TRIAL_W'(act_width)) : POS_W'(col_trial);

		nr_dec  = (nr_q == '0) ? POS_W'(act_height - 1'b1) : nr_q - 1'b1;
		nc0_dec = (nc0_q == '0) ? POS_W'(act_width - 1'b1) : nc0_q - 1'b1;
		nr_inc  = (SZ_W'(nr_q) + 1'b1 == act_height) ? '0 : nr_q + 1'b1;
		nc_inc  = (SZ_W'(nc_q) + 1'b1 == act_width) ? '0 : nc_q + 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_start) begin
			nr_q    <= '0;
			nc_q    <= '0;
			nc0_q   <= '0;
			rowsh_q <= row;
			colsh_q <= col;
			kidx_q  <= '0;
		end else if (cmd.mod_step) begin
			nr_q    <= nr_mod;
			nc_q    <= nc_mod;
			nc0_q   <= nc_mod;
			rowsh_q <= rowsh_q << 1;
			colsh_q <= colsh_q << 1;
		end else if (cmd.back_step) begin
			nr_q  <= nr_dec;
			nc0_q <= nc0_dec;
			nc_q  <= nc0_dec;
		end else if (cmd.issue) begin
			kidx_q <= kidx_q + 1'b1;
			if (cmd.row_end) begin
				nc_q <= nc0_q;
				nr_q <= nr_inc;
			end else begin
				nc_q <= nc_inc;
			end
		end
	end

	assign kern_we = cmd.coef_we && (32'(coef_index) < KDEPTH);

	wic_ram #(.WIDTH(PIX_W), .DEPTH(FDEPTH)) u_frame (
		.clk   (clk),
		.we    (cmd.pixel_we),
		.waddr ({POS_W'(row), POS_W'(col)}),
		.wdata ({blue, green, red}),
		.raddr ({nr_q, nc_q}),
		.rdata (pix_rd)
	);

	wic_ram #(.WIDTH(COEF_W), .DEPTH(KDEPTH)) u_kernel (
		.clk   (clk),
		.we    (kern_we),
		.waddr (KA_W'(coef_index)),
		.wdata (coef_value),
		.raddr (kidx_q),
		.rdata (coef_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			v_s1    <= cmd.issue;
			last_s1 <= cmd.issue && cmd.last;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_r_s2 <= $signed(coef_rd) * $signed({1'b0, pix_rd[CHAN_W-1:0]});
		prod_g_s2 <= $signed(coef_rd) * $signed({1'b0, pix_rd[2*CHAN_W-1:CHAN_W]});
		prod_b_s2 <= $signed(coef_rd) * $signed({1'b0, pix_rd[PIX_W-1:2*CHAN_W]});

		if (cmd.mod_start) begin
			acc_r_q <= '0;
			acc_g_q <= '0;
			acc_b_q <= '0;
		end else if (v_s2) begin
			acc_r_q <= acc_r_q + ACC_W'(prod_r_s2);
			acc_g_q <= acc_g_q + ACC_W'(prod_g_s2);
			acc_b_q <= acc_b_q + ACC_W'(prod_b_s2);
		end
	end

	assign status.acc_done = v_s2 && last_s2;
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_red_q   <= abs_low(acc_r_q);
			out_green_q <= abs_low(acc_g_q);
			out_blue_q  <= abs_low(acc_b_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_red   = out_red_q;
	assign out_green = out_green_q;
	assign out_blue  = out_blue_q;

endmodule

`default_nettype wire

// ===== hdl/wrapped_image_convolution_unit.sv =====
// Top level of the wrapped image convolution unit.
`timescale 1ns / 1ps
`default_nettype none

// Holds an RGB frame of MAX_SIDE x MAX_SIDE pixels and a signed kernel of up to
// MAX_KERNEL x MAX_KERNEL taps, both in RAM with no reset, so every pixel and coefficient
// must be written before a compute reads it. MAX_SIDE must be a power of two. Coefficient
// and pixel writes leave the block ready for the next item. A compute reduces row and
// column modulo the active height and width one bit at a time, moves the window origin
// back by half a kernel across the wrapped edges, then the single frame-store read port
// fetches one tap per cycle into a three-stage multiply-accumulate. The result sits in an
// output register, so the next item is taken while it waits; a following compute stalls
// only at its end if the previous result has still not been taken. Register writes are
// accepted in any cycle.
module wrapped_image_convolution_unit import wic_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF,
	parameter int MAX_KERNEL = MAX_KERNEL_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	wic_in_if.sink     item,
	wic_out_if.source  result,
	wic_cfg_if.sink    cfg
);

	localparam int SZ_W = $clog2(MAX_SIDE + 1);
	localparam int KS_W = $clog2(MAX_KERNEL + 1);

	logic [SZ_W-1:0] act_width, act_height;
	logic [KS_W-1:0] act_ksize, act_half;
	ctrl_cmd_t       cmd;
	dp_status_t      status;

	wic_cfg #(.MAX_SIDE(MAX_SIDE), .MAX_KERNEL(MAX_KERNEL)) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.act_width  (act_width),
		.act_height (act_height),
		.act_ksize  (act_ksize),
		.act_half   (act_half)
	);

	wic_ctrl #(.MAX_KERNEL(MAX_KERNEL)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_command (item.command),
		.item_ready   (item.ready),
		.act_ksize    (act_ksize),
		.act_half     (act_half),
		.cmd          (cmd),
		.status       (status)
	);

	wic_dp #(.MAX_SIDE(MAX_SIDE), .MAX_KERNEL(MAX_KERNEL)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.act_width  (act_width),
		.act_height (act_height),
		.row        (item.row),
		.col        (item.col),
		.coef_index (item.coef_index),
		.coef_value (item.coef_value),
		.red        (item.red),
		.green      (item.green),
		.blue       (item.blue),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_red    (result.out_red),
		.out_green  (result.out_green),
		.out_blue   (result.out_blue)
	);

endmodule

`default_nettype wire

// ===== test/tb_wrapped_image_convolution_unit.sv =====
// Self-checking testbench for the wrapped image convolution unit: directed table, then random phases.
`timescale 1ns / 1ps

module tb_wrapped_image_convolution_unit;
	import wic_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 12;
	localparam int DRAIN_CYCLES = 50;
	localparam int QUIET_LIMIT  = 2000;
	localparam int KERNEL_TAPS  = MAX_KERNEL_DEF * MAX_KERNEL_DEF;
	localparam int FRAME_CELLS  = MAX_SIDE_DEF * MAX_SIDE_DEF;
	localparam int NUM_PHASES   = 9;
	localparam int PHASE_ITEMS  = 122;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic [POS_IN_W-1:0]      row;
		logic [POS_IN_W-1:0]      col;
		logic [COEF_IDX_W-1:0]    coef_index;
		logic signed [COEF_W-1:0] coef_value;
		logic [CHAN_W-1:0]        red;
		logic [CHAN_W-1:0]        green;
		logic [CHAN_W-1:0]        blue;
	} pixel_cmd_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
	} rgb_t;

	typedef struct packed {
		bit                    is_reg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_data;
		pixel_cmd_t            cmd;
		bit                    typed;
		rgb_t                  want;
	} directed_op_t;

	localparam rgb_t NO_RGB = '0;

	logic clk;
	logic arst_n;

	wic_in_if  item_ch ();
	wic_out_if result_ch ();
	wic_cfg_if cfg_ch ();

	wrapped_image_convolution_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the frame, the kernel and the registers.
	logic [3*CHAN_W-1:0]      pix_mem [FRAME_CELLS];
	bit                       pix_set [FRAME_CELLS];
	logic signed [COEF_W-1:0] coef_mem [KERNEL_TAPS];
	bit                       coef_set [KERNEL_TAPS];
	logic [SIDE_CFG_W-1:0]    reg_width;
	logic [SIDE_CFG_W-1:0]    reg_height;
	logic [KSIZE_CFG_W-1:0]   reg_ksize;

	rgb_t         expected_pixels [$];
	directed_op_t directed_ops [$];
	int send_idle;
	int recv_idle;
	int mismatches;
	int quiet_cycles;

	// Register settings of the random phases, extremes and out-of-range values among them.
	logic [CFG_DATA_W-1:0] phase_width [NUM_PHASES] =
		'{9'd5, 9'd511, 9'd1, 9'd3, 9'd256, 9'd9, 9'd257, 9'd6, 9'd2};
	logic [CFG_DATA_W-1:0] phase_height [NUM_PHASES] =
		'{9'd4, 9'd256, 9'd7, 9'd3, 9'd1, 9'd2, 9'd300, 9'd5, 9'd256};
	logic [CFG_DATA_W-1:0] phase_ksize [NUM_PHASES] =
		'{9'd3, 9'd7, 9'd5, 9'h1FE, 9'd2, 9'd5, 9'd0, 9'd4, 9'd5};

	function automatic int active_side(logic [SIDE_CFG_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_SIDE_DEF) return MAX_SIDE_DEF;
		return int'(v);
	endfunction

	function automatic int active_ksize();
		int k;
		k = int'(reg_ksize);
		if (k > MAX_KERNEL_DEF) k = MAX_KERNEL_DEF;
		if (k == 0) k = 1;
		if (k % 2 == 0) k--;
		return k;
	endfunction

	function automatic int wrap_index(int v, int n);
		int m;
		m = v % n;
		if (m < 0) m += n;
		return m;
	endfunction

	// Frame address of kernel tap (a, b) for the window centered at row, col.
	function automatic logic [2*POS_IN_W-1:0] tap_addr(logic [POS_IN_W-1:0] row,
			logic [POS_IN_W-1:0] col, int a, int b);
		int w, h, half, nr, nc;
		w = active_side(reg_width);
		h = active_side(reg_height);
		half = active_ksize() / 2;
		nr = wrap_index(int'(row) % h + a - half, h);
		nc = wrap_index(int'(col) % w + b - half, w);
		return {nr[POS_IN_W-1:0], nc[POS_IN_W-1:0]};
	endfunction

	function automatic rgb_t convolve_at(logic [POS_IN_W-1:0] row, logic [POS_IN_W-1:0] col);
		int k, sr, sg, sb, tap;
		logic [3*CHAN_W-1:0] px;
		rgb_t res;
		k = active_ksize();
		sr = 0;
		sg = 0;
		sb = 0;
		for (int a = 0; a < k; a++) begin
			for (int b = 0; b < k; b++) begin
				px = pix_mem[tap_addr(row, col, a, b)];
				tap = coef_mem[a * k + b];
				sr += tap * int'(px[CHAN_W-1:0]);
				sg += tap * int'(px[2*CHAN_W-1:CHAN_W]);
				sb += tap * int'(px[3*CHAN_W-1:2*CHAN_W]);
			end
		end
		if (sr < 0) sr = -sr;
		if (sg < 0) sg = -sg;
		if (sb < 0) sb = -sb;
		res.out_red = sr[CHAN_W-1:0];
		res.out_green = sg[CHAN_W-1:0];
		res.out_blue = sb[CHAN_W-1:0];
		return res;
	endfunction

	function automatic logic [CHAN_W-1:0] rand_chan();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) return '0;
		if (pick == 1) return '1;
		return CHAN_W'($urandom_range(255));
	endfunction

	function automatic logic signed [COEF_W-1:0] rand_coef();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) return 8'sh80;
		if (pick == 1) return 8'sh7F;
		return COEF_W'($urandom_range(255));
	endfunction

	// Every field random, so that unused fields toggle too.
	function automatic pixel_cmd_t scrambled_cmd();
		pixel_cmd_t c;
		c.command = CMD_W'($urandom_range(3));
		c.row = POS_IN_W'($urandom_range(255));
		c.col = POS_IN_W'($urandom_range(255));
		c.coef_index = COEF_IDX_W'($urandom_range(31));
		c.coef_value = COEF_W'($urandom_range(255));
		c.red = CHAN_W'($urandom_range(255));
		c.green = CHAN_W'($urandom_range(255));
		c.blue = CHAN_W'($urandom_range(255));
		return c;
	endfunction

	function automatic pixel_cmd_t make_cmd(logic [CMD_W-1:0] command,
			logic [POS_IN_W-1:0] row, logic [POS_IN_W-1:0] col,
			logic [COEF_IDX_W-1:0] idx, logic signed [COEF_W-1:0] value,
			logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
		pixel_cmd_t c;
		c.command = command;
		c.row = row;
		c.col = col;
		c.coef_index = idx;
		c.coef_value = value;
		c.red = r;
		c.green = g;
		c.blue = b;
		return c;
	endfunction

	function automatic void add_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		directed_op_t op;
		op = '0;
		op.is_reg = 1'b1;
		op.reg_idx = idx;
		op.reg_data = data;
		directed_ops.push_back(op);
	endfunction

	function automatic void add_cmd(pixel_cmd_t c);
		directed_op_t op;
		op = '0;
		op.cmd = c;
		directed_ops.push_back(op);
	endfunction

	function automatic void add_checked(logic [POS_IN_W-1:0] row, logic [POS_IN_W-1:0] col,
			logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g, logic [CHAN_W-1:0] b);
		directed_op_t op;
		op = '0;
		op.cmd = make_cmd(CMD_CONV, row, col, '0, '0, '0, '0, '0);
		op.typed = 1'b1;
		op.want = {r, g, b};
		directed_ops.push_back(op);
	endfunction

	// Drives one item, waits for its transfer and updates the shadow state.
	task automatic send_cmd(input pixel_cmd_t c, input bit typed, input rgb_t typed_val);
		while ($urandom_range(99) < send_idle) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.command <= c.command;
		item_ch.row <= c.row;
		item_ch.col <= c.col;
		item_ch.coef_index <= c.coef_index;
		item_ch.coef_value <= c.coef_value;
		item_ch.red <= c.red;
		item_ch.green <= c.green;
		item_ch.blue <= c.blue;
		do @(posedge clk); while (!item_ch.ready);
		case (c.command)
			CMD_COEF: begin
				if (c.coef_index < KERNEL_TAPS) begin
					coef_mem[c.coef_index] = c.coef_value;
					coef_set[c.coef_index] = 1'b1;
				end
			end
			CMD_PIXEL: begin
				pix_mem[{c.row, c.col}] = {c.blue, c.green, c.red};
				pix_set[{c.row, c.col}] = 1'b1;
			end
			CMD_CONV: begin
				expected_pixels.push_back(typed ? typed_val : convolve_at(c.row, c.col));
			end
			default: ;
		endcase
	endtask

	// Register writes happen only once the block has drained.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		item_ch.valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_WIDTH:  reg_width = data[SIDE_CFG_W-1:0];
			REG_HEIGHT: reg_height = data[SIDE_CFG_W-1:0];
			REG_KSIZE:  reg_ksize = data[KSIZE_CFG_W-1:0];
			default: ;
		endcase
	endtask

	task automatic check_chan(input string name, input logic [CHAN_W-1:0] want,
			input logic [CHAN_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		rgb_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_pixels.size() == 0) begin
				$display("%0t: result with nothing expected, got %0d %0d %0d", $time,
					result_ch.out_red, result_ch.out_green, result_ch.out_blue);
				mismatches++;
			end else begin
				want = expected_pixels.pop_front();
				check_chan("out_red", want.out_red, result_ch.out_red);
				check_chan("out_green", want.out_green, result_ch.out_green);
				check_chan("out_blue", want.out_blue, result_ch.out_blue);
			end
		end
	end

	// Watchdog: too long without any transfer on any channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL wrapped_image_convolution_unit");
				$finish;
			end
		end
	end

	initial begin
		pixel_cmd_t c;
		int count, pick, k;
		logic [POS_IN_W-1:0] row, col;
		logic [2*POS_IN_W-1:0] addr;

		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.command <= CMD_COEF;
		item_ch.row <= '0;
		item_ch.col <= '0;
		item_ch.coef_index <= '0;
		item_ch.coef_value <= '0;
		item_ch.red <= '0;
		item_ch.green <= '0;
		item_ch.blue <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_WIDTH;
		cfg_ch.data <= '0;
		mismatches = 0;
		quiet_cycles = 0;
		send_idle = 25;
		recv_idle = 48;
		reg_width = RST_WIDTH;
		reg_height = RST_HEIGHT;
		reg_ksize = RST_KSIZE;
		for (int i = 0; i < FRAME_CELLS; i++) pix_set[i] = 1'b0;
		for (int i = 0; i < KERNEL_TAPS; i++) coef_set[i] = 1'b0;

		// Single tap at full size, corners of the frame, coefficient extremes.
		add_reg(REG_KSIZE, 9'd1);
		add_cmd(make_cmd(CMD_COEF, 8'd0, 8'd0, 5'd0, 8'sh80, 8'd0, 8'd0, 8'd0));
		add_cmd(make_cmd(CMD_COEF, 8'd0, 8'd0, 5'd31, 8'sh7F, 8'd0, 8'd0, 8'd0));
		add_cmd(make_cmd(CMD_PIXEL, 8'd0, 8'd0, 5'd0, 8'sh00, 8'd255, 8'd255, 8'd255));
		add_checked(8'd0, 8'd0, 8'h80, 8'h80, 8'h80);
		add_cmd(make_cmd(CMD_PIXEL, 8'd255, 8'd255, 5'd0, 8'sh00, 8'd1, 8'd2, 8'd3));
		add_checked(8'd255, 8'd255, 8'h80, 8'h00, 8'h80);
		add_cmd(make_cmd(CMD_COEF, 8'd0, 8'd0, 5'd0, 8'sh7F, 8'd0, 8'd0, 8'd0));
		add_checked(8'd255, 8'd255, 8'd127, 8'd254, 8'd125);
		add_cmd(make_cmd(CMD_UNUSED, 8'd255, 8'd255, 5'd31, 8'shFF, 8'd255, 8'd255, 8'd255));
		// A zero size saturates to one, so every position folds onto the origin.
		add_reg(REG_WIDTH, 9'd0);
		add_reg(REG_HEIGHT, 9'd0);
		add_checked(8'd255, 8'd255, 8'h81, 8'h81, 8'h81);
		// An even kernel side drops to the odd one below it.
		add_reg(REG_KSIZE, 9'd4);
		for (int i = 1; i < 9; i++)
			add_cmd(make_cmd(CMD_COEF, 8'd0, 8'd0, COEF_IDX_W'(i), 8'shFF, 8'd0, 8'd0, 8'd0));
		add_cmd(make_cmd(CMD_COEF, 8'd0, 8'd0, 5'd25, 8'sh7F, 8'd0, 8'd0, 8'd0));
		add_cmd(make_cmd(CMD_PIXEL, 8'd0, 8'd0, 5'd0, 8'sh00, 8'd1, 8'd2, 8'd3));
		add_checked(8'd77, 8'd200, 8'd119, 8'd238, 8'd101);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_ops[i]) begin
			if (directed_ops[i].is_reg)
				write_reg(directed_ops[i].reg_idx, directed_ops[i].reg_data);
			else
				send_cmd(directed_ops[i].cmd, directed_ops[i].typed, directed_ops[i].want);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < 3) begin
				send_idle = 25;
				recv_idle = 48;
			end else if (p < 6) begin
				send_idle = 48;
				recv_idle = 25;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_reg(REG_WIDTH, phase_width[p]);
			write_reg(REG_HEIGHT, phase_height[p]);
			write_reg(REG_KSIZE, phase_ksize[p]);
			count = 0;
			while (count < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				c = scrambled_cmd();
				if (pick < 45) begin
					if ($urandom_range(1)) begin
						row = POS_IN_W'($urandom_range(255));
						col = POS_IN_W'($urandom_range(255));
					end else begin
						row = POS_IN_W'($urandom_range(active_side(reg_height) - 1));
						col = POS_IN_W'($urandom_range(active_side(reg_width) - 1));
					end
					// Fill any pixel or coefficient of the window that was never written.
					k = active_ksize();
					for (int a = 0; a < k; a++) begin
						for (int b = 0; b < k; b++) begin
							addr = tap_addr(row, col, a, b);
							if (!pix_set[addr]) begin
								c = scrambled_cmd();
								c.command = CMD_PIXEL;
								c.row = addr[2*POS_IN_W-1:POS_IN_W];
								c.col = addr[POS_IN_W-1:0];
								c.red = rand_chan();
								c.green = rand_chan();
								c.blue = rand_chan();
								send_cmd(c, 1'b0, NO_RGB);
								count++;
							end
							if (!coef_set[a * k + b]) begin
								c = scrambled_cmd();
								c.command = CMD_COEF;
								c.coef_index = COEF_IDX_W'(a * k + b);
								c.coef_value = rand_coef();
								send_cmd(c, 1'b0, NO_RGB);
								count++;
							end
						end
					end
					c = scrambled_cmd();
					c.command = CMD_CONV;
					c.row = row;
					c.col = col;
					send_cmd(c, 1'b0, NO_RGB);
					count++;
				end else if (pick < 75) begin
					c.command = CMD_PIXEL;
					if ($urandom_range(1)) begin
						c.row = POS_IN_W'($urandom_range(active_side(reg_height) - 1));
						c.col = POS_IN_W'($urandom_range(active_side(reg_width) - 1));
					end
					c.red = rand_chan();
					c.green = rand_chan();
					c.blue = rand_chan();
					send_cmd(c, 1'b0, NO_RGB);
					count++;
				end else if (pick < 88) begin
					c.command = CMD_COEF;
					c.coef_index = COEF_IDX_W'($urandom_range(KERNEL_TAPS - 1));
					c.coef_value = rand_coef();
					send_cmd(c, 1'b0, NO_RGB);
					count++;
				end else if (pick < 94) begin
					// Index past the kernel store: the block drops it.
					c.command = CMD_COEF;
					c.coef_index = COEF_IDX_W'($urandom_range(31, KERNEL_TAPS));
					send_cmd(c, 1'b0, NO_RGB);
					count++;
				end else begin
					c.command = CMD_UNUSED;
					send_cmd(c, 1'b0, NO_RGB);
					count++;
				end
			end
		end

		item_ch.valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("PASS wrapped_image_convolution_unit");
		else
			$display("FAIL wrapped_image_convolution_unit");
		$finish;
	end

endmodule
